// File: hw/rtl/rlrld_pkg.sv
// ----------------------------------------------------------------------------
// rlrld_pkg
// shared types, constants and the 16-bit sample reduction of the raster
// line run-length decoder
// ----------------------------------------------------------------------------
package rlrld_pkg;

    // configuration register indexes
    localparam logic CFG_LINE_WIDTH  = 1'b0;
    localparam logic CFG_SIXTEEN_BIT = 1'b1;

    localparam int CFG_DATA_W  = 14;
    localparam int COLUMN_W    = 13;
    localparam int WIDTH_W     = 14;
    localparam int RUN_W       = 8;
    localparam int COPIES_W    = 9;
    localparam int PIX_BYTES   = 6;

    localparam logic [WIDTH_W-1:0] MAX_LINE_PIXELS = 14'd8192;

    // bytes per pixel at each depth
    localparam logic [2:0] BPP_8  = 3'd3;
    localparam logic [2:0] BPP_16 = 3'd6;

    // ceil(2^24 / 257), exact for all 17-bit dividends
    localparam logic [16:0] RECIP_257 = 17'd65281;
    localparam logic [16:0] ROUND_129 = 17'd129;

    typedef enum logic [3:0] {
        PH_COPY  = 4'b0001,
        PH_RUN   = 4'b0010,
        PH_PIXEL = 4'b0100,
        PH_SKIP  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef logic [PIX_BYTES*8-1:0] sample_t;

    // (s + 129) / 257 by multiplication with the reciprocal
    function automatic logic [7:0] reduce16(input logic [15:0] s);
        logic [16:0] x;
        logic [33:0] p;
        x = {1'b0, s} + ROUND_129;
        p = {17'd0, x} * {17'd0, RECIP_257};
        return p[31:24];
    endfunction

endpackage

// File: hw/rtl/rlrld_ifs.sv
// ----------------------------------------------------------------------------
// rlrld channels
// valid/ready channels for compressed bytes and decoded runs
// ----------------------------------------------------------------------------
interface rlrld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rlrld_run_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] start_column;
    logic [7:0]  run_length;
    logic [8:0]  line_copies;
    logic        end_of_line;
    logic        overrun;

    modport source (
        output valid, output red, output green, output blue,
        output start_column, output run_length, output line_copies,
        output end_of_line, output overrun,
        input ready
    );
    modport sink (
        input valid, input red, input green, input blue,
        input start_column, input run_length, input line_copies,
        input end_of_line, input overrun,
        output ready
    );
endinterface

// File: hw/rtl/raster_line_run_length_decoder_core.sv
// ----------------------------------------------------------------------------
// raster_line_run_length_decoder_core
// decodes a packbits-style compressed raster line, one byte per transaction,
// into runs of identical pixels with column, length and line copy count
// ----------------------------------------------------------------------------
// throughput: one byte per cycle, set by the single decode stage, while no pending run stalls it
// a run's last byte is held in the input reg, then its run in the result reg;
//   the run waits in the result reg until runs.ready takes it
// reset: waits for a line copy byte; line_width 1, 8-bit samples
// no clearing pass; all control state is cleared at once by rst_n
module raster_line_run_length_decoder_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [rlrld_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    rlrld_byte_if.sink                           bytes,
    rlrld_run_if.source                          runs
);

    // configuration
    logic [rlrld_pkg::WIDTH_W-1:0]   width_reg;
    logic                            sixteen_reg;

    // input register stage
    logic                            s1_valid_reg;
    logic [7:0]                      s1_byte_reg;

    // decode state
    rlrld_pkg::phase_t               phase_reg, phase_next;
    logic [rlrld_pkg::COPIES_W-1:0]  copies_reg, copies_next;
    logic [rlrld_pkg::COLUMN_W-1:0]  column_reg, column_next;
    logic [rlrld_pkg::RUN_W-1:0]     run_left_reg, run_left_next;
    logic                            literal_reg, literal_next;
    logic [2:0]                      idx_reg, idx_next;
    logic [7:0]                      asm_reg [rlrld_pkg::PIX_BYTES];

    // result register
    logic                            out_valid_reg, out_valid_next;
    rlrld_pkg::pixel_t               out_pixel_reg;
    logic [rlrld_pkg::COLUMN_W-1:0]  out_column_reg;
    logic [rlrld_pkg::RUN_W-1:0]     out_len_reg;
    logic [rlrld_pkg::COPIES_W-1:0]  out_copies_reg;
    logic                            out_eol_reg;
    logic                            out_ovr_reg;

    // decode signals
    logic                            s1_fire;
    logic                            collecting;
    logic                            has_result;
    rlrld_pkg::sample_t              samples;
    rlrld_pkg::pixel_t               pixel;
    logic [2:0]                      bpp;
    logic [2:0]                      idx_inc;
    logic                            pix_done;
    logic [rlrld_pkg::WIDTH_W-1:0]   eff_w;
    logic [rlrld_pkg::WIDTH_W-1:0]   col_ext;
    logic [rlrld_pkg::WIDTH_W-1:0]   left;
    logic [rlrld_pkg::RUN_W-1:0]     len0;
    logic [rlrld_pkg::RUN_W-1:0]     len;
    logic [rlrld_pkg::RUN_W-1:0]     rl_after;
    logic                            past_end;
    logic                            eol;
    logic                            ovr;

    // ------------------------------------------------------------------
    // handshakes: stage 1 moves on when the result register is free or
    // being drained, so a pending run that is not taken stalls the next byte
    // ------------------------------------------------------------------
    assign s1_fire     = s1_valid_reg && (!out_valid_reg || runs.ready);
    assign bytes.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            s1_byte_reg <= bytes.data_byte;
        end
    end

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 14'd1;
            sixteen_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rlrld_pkg::CFG_LINE_WIDTH:  width_reg   <= cfg_wdata;
                rlrld_pkg::CFG_SIXTEEN_BIT: sixteen_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pixel assembly: the byte in stage 1 is merged into the collected
    // bytes so a pixel completes in the cycle its last byte is decoded
    // ------------------------------------------------------------------
    assign bpp     = sixteen_reg ? rlrld_pkg::BPP_16 : rlrld_pkg::BPP_8;
    assign idx_inc = idx_reg + 3'd1;
    // 3-bit compare; the byte index stays below 6, so the increment never wraps
    assign pix_done = (idx_inc >= bpp);

    always_comb
    begin
        for (int k = 0; k < rlrld_pkg::PIX_BYTES; k++)
        begin
            samples[k*8 +: 8] = (idx_reg == 3'(k)) ? s1_byte_reg : asm_reg[k];
        end
    end

    rlrld_pixel_color u_color (
        .sixteen_bit (sixteen_reg),
        .samples     (samples),
        .pixel       (pixel)
    );

    // ------------------------------------------------------------------
    // run geometry: effective width, pixels left in the line, clipping
    // ------------------------------------------------------------------
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = 14'd1;
        end
        else if (width_reg > rlrld_pkg::MAX_LINE_PIXELS)
        begin
            eff_w = rlrld_pkg::MAX_LINE_PIXELS;
        end
        else
        begin
            eff_w = width_reg;
        end
    end

    assign col_ext  = {1'b0, column_reg};
    assign past_end = (col_ext >= eff_w);
    assign left     = past_end ? '0 : (eff_w - col_ext);

    always_comb
    begin
        // literal pixels go out one at a time
        len0 = literal_reg ? 8'd1 : run_left_reg;
        if (len0 == '0)
        begin
            len0 = 8'd1;
        end

        ovr = 1'b0;
        len = len0;
        if (past_end)
        begin
            // width lowered under the current column
            len = 8'd1;
            ovr = 1'b1;
        end
        else if ({6'd0, len0} > left)
        begin
            len = left[rlrld_pkg::RUN_W-1:0];
            ovr = 1'b1;
        end

        rl_after = (literal_reg && run_left_reg != '0) ? run_left_reg - 8'd1 : '0;
        eol      = past_end || ({6'd0, len} >= left);
        if (eol && rl_after != '0)
        begin
            // rest of the literal run falls off the line
            ovr = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // decode state update
    // ------------------------------------------------------------------
    assign collecting = (phase_reg == rlrld_pkg::PH_PIXEL) ||
                        (phase_reg == rlrld_pkg::PH_SKIP);

    always_comb
    begin
        phase_next    = phase_reg;
        copies_next   = copies_reg;
        column_next   = column_reg;
        run_left_next = run_left_reg;
        literal_next  = literal_reg;
        idx_next      = idx_reg;
        has_result    = 1'b0;

        case (phase_reg)
            rlrld_pkg::PH_COPY:
            begin
                copies_next = {1'b0, s1_byte_reg} + 9'd1;
                column_next = '0;
                phase_next  = rlrld_pkg::PH_RUN;
            end
            rlrld_pkg::PH_RUN:
            begin
                literal_next = s1_byte_reg[7];
                if (s1_byte_reg[7])
                begin
                    run_left_next = 8'(9'd257 - {1'b0, s1_byte_reg});
                end
                else
                begin
                    run_left_next = s1_byte_reg + 8'd1;
                end
                idx_next   = '0;
                phase_next = rlrld_pkg::PH_PIXEL;
            end
            rlrld_pkg::PH_PIXEL:
            begin
                idx_next = idx_inc;
                if (pix_done)
                begin
                    idx_next      = '0;
                    has_result    = 1'b1;
                    run_left_next = rl_after;
                    if (eol)
                    begin
                        column_next = '0;
                        phase_next  = (rl_after != '0) ? rlrld_pkg::PH_SKIP
                                                       : rlrld_pkg::PH_COPY;
                    end
                    else
                    begin
                        column_next = column_reg + rlrld_pkg::COLUMN_W'(len);
                        phase_next  = (rl_after != '0) ? rlrld_pkg::PH_PIXEL
                                                       : rlrld_pkg::PH_RUN;
                    end
                end
            end
            rlrld_pkg::PH_SKIP:
            begin
                idx_next = idx_inc;
                if (pix_done)
                begin
                    idx_next = '0;
                    if (run_left_reg != '0)
                    begin
                        run_left_next = run_left_reg - 8'd1;
                    end
                    if (run_left_reg <= 8'd1)
                    begin
                        phase_next = rlrld_pkg::PH_COPY;
                    end
                end
            end
            default:
            begin
                phase_next = rlrld_pkg::PH_COPY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rlrld_pkg::PH_COPY;
            copies_reg   <= 9'd1;
            column_reg   <= '0;
            run_left_reg <= '0;
            literal_reg  <= 1'b0;
            idx_reg      <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg    <= phase_next;
            copies_reg   <= copies_next;
            column_reg   <= column_next;
            run_left_reg <= run_left_next;
            literal_reg  <= literal_next;
            idx_reg      <= idx_next;
        end
    end

    // collected pixel bytes, one lane per byte position
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < rlrld_pkg::PIX_BYTES; k++)
        begin
            if (s1_fire && collecting && idx_reg == 3'(k))
            begin
                asm_reg[k] <= s1_byte_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = has_result;
        end
        else if (runs.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_pixel_reg  <= pixel;
            out_column_reg <= column_reg;
            out_len_reg    <= len;
            out_copies_reg <= copies_reg;
            out_eol_reg    <= eol;
            out_ovr_reg    <= ovr;
        end
    end

    assign runs.valid        = out_valid_reg;
    assign runs.red          = out_pixel_reg.red;
    assign runs.green        = out_pixel_reg.green;
    assign runs.blue         = out_pixel_reg.blue;
    assign runs.start_column = out_column_reg;
    assign runs.run_length   = out_len_reg;
    assign runs.line_copies  = out_copies_reg;
    assign runs.end_of_line  = out_eol_reg;
    assign runs.overrun      = out_ovr_reg;

endmodule

// File: hw/rtl/rlrld_pixel_color.sv
// ----------------------------------------------------------------------------
// rlrld_pixel_color
// turns the collected pixel bytes into an 8-bit rgb triple
// ----------------------------------------------------------------------------
module rlrld_pixel_color (
    input  logic               sixteen_bit,
    input  rlrld_pkg::sample_t samples,
    output rlrld_pkg::pixel_t  pixel
);

    always_comb
    begin
        if (sixteen_bit)
        begin
            // little-endian 16-bit samples
            pixel.red   = rlrld_pkg::reduce16(samples[15:0]);
            pixel.green = rlrld_pkg::reduce16(samples[31:16]);
            pixel.blue  = rlrld_pkg::reduce16(samples[47:32]);
        end
        else
        begin
            pixel.red   = samples[7:0];
            pixel.green = samples[15:8];
            pixel.blue  = samples[23:16];
        end
    end

endmodule
